FILE: sv/wsra_pkg.sv
// wsra_pkg: shared types, widths and helpers for the windowed source rate alarm
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none

package wsra_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned THR_W    = 6;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned MCOUNT_W = 7;
  // wide enough for the count at the largest supported log depth of 1024
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned GRP_W    = 4;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_WINDOW    = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    T_IDLE  = 1'b0,
    T_ACCUM = 1'b1
  } tally_state_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] src;
    logic [TIME_W-1:0] tstamp;
  } entry_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } tally_res_t;

  function automatic logic [GRP_W-1:0] popcount8(input logic [7:0] bits);
    logic [GRP_W-1:0] sum;
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + GRP_W'(bits[k]);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

FILE: sv/wsra_if.sv
// wsra_req_if / wsra_rsp_if: valid-ready channels for attempts and verdicts
// depends on wsra_pkg for field widths
`default_nettype none

interface wsra_req_if;
  import wsra_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] src_addr;
  logic [TIME_W-1:0] now_seconds;
  modport source (output valid, src_addr, now_seconds, input ready);
  modport sink   (input valid, src_addr, now_seconds, output ready);
endinterface

interface wsra_rsp_if;
  import wsra_pkg::*;
  logic                valid;
  logic                ready;
  logic                alert;
  logic [MCOUNT_W-1:0] match_count;
  modport source (output valid, alert, match_count, input ready);
  modport sink   (input valid, alert, match_count, output ready);
endinterface

`default_nettype wire

FILE: sv/wsra_cell.sv
// wsra_cell: one log slot of the shifting log, with its own window match
// depends on wsra_pkg (entry_t, widths)
`default_nettype none

module wsra_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     shift,
  input  wire wsra_pkg::entry_t         entry_in,
  input  wire logic [wsra_pkg::ADDR_W-1:0] key_src,
  input  wire logic [wsra_pkg::TIME_W-1:0] key_time,
  input  wire logic [wsra_pkg::WIN_W-1:0]  window,
  output wsra_pkg::entry_t              entry,
  output logic                          hit
);
  import wsra_pkg::*;

  logic [TIME_W-1:0] age;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry.src    <= entry_in.src;
      entry.tstamp <= entry_in.tstamp;
    end
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry.valid <= entry_in.valid;
    end
  end

  // age wraps modulo 2^32, so a stamp from the future never counts
  assign age = key_time - entry.tstamp;
  assign hit = entry.valid && (entry.src == key_src) && (age <= TIME_W'(window));

endmodule

`default_nettype wire

FILE: sv/wsra_tally.sv
// wsra_tally: counts the registered hit vector, eight hits per group, then
// eight group sums per cycle through a shifting row; depends on wsra_pkg
`default_nettype none

module wsra_tally #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DEPTH-1:0] hits,
  output wsra_pkg::tally_res_t  res
);
  import wsra_pkg::*;

  localparam int unsigned NG  = (DEPTH + 7) / 8;
  localparam int unsigned NP  = (NG + 7) / 8;
  localparam int unsigned NS  = NP * 8;
  localparam int unsigned PAD = NG * 8;
  localparam int unsigned PW  = (NP > 1) ? $clog2(NP) : 1;

  tally_state_t      state, state_next;
  logic [PAD-1:0]    hits_pad;
  logic [GRP_W-1:0]  grp [NS];
  logic [PW-1:0]     pass;
  logic [CNT_W-1:0]  acc;
  logic [CNT_W-1:0]  lane_sum;
  logic              last_pass;

  assign hits_pad  = PAD'(hits);
  assign last_pass = (pass == PW'(NP - 1));

  always_comb begin
    lane_sum = '0;
    for (int k = 0; k < 8; k++) begin
      lane_sum = lane_sum + CNT_W'(grp[k]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: begin
        if (start) state_next = T_ACCUM;
      end
      T_ACCUM: begin
        if (last_pass) state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      pass     <= '0;
      res.done <= 1'b0;
    end else begin
      state    <= state_next;
      res.done <= (state == T_ACCUM) && last_pass;
      if (state == T_ACCUM) begin
        pass <= last_pass ? '0 : pass + PW'(1);
        if (last_pass) res.count <= acc + lane_sum;
      end
    end
  end

  // group sums are loaded at start and shift down eight places per pass
  always_ff @(posedge clk) begin
    if (state == T_IDLE && start) begin
      acc <= '0;
      for (int g = 0; g < NG; g++) begin
        grp[g] <= popcount8(hits_pad[g*8 +: 8]);
      end
      for (int g = NG; g < NS; g++) begin
        grp[g] <= '0;
      end
    end else if (state == T_ACCUM) begin
      acc <= acc + lane_sum;
      for (int g = 0; g < NS - 8; g++) begin
        grp[g] <= grp[g+8];
      end
      for (int g = NS - 8; g < NS; g++) begin
        grp[g] <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/windowed_source_rate_alarm.sv
// windowed_source_rate_alarm: top level; shifting log of attempt cells,
// hit tally, result register and APB register block; uses wsra_pkg, wsra_if
//
//   channel | role  | beat
//   req     | sink  | src_addr, now_seconds (one connection attempt)
//   rsp     | source| alert, match_count (one verdict per attempt)
//   apb     | slave | alarm_threshold at 0x0, window_seconds at 0x4
//
// one attempt at a time: a new beat is taken only once the last verdict is on rsp;
// the tally adds eight group sums of eight hits per cycle.
// the attempt enters the cell row at its beat and every cell compares in parallel.
// a verdict waiting on rsp does not block the next attempt; a second verdict
// is held until the first is taken.
// reset empties the log at once; the registers return to threshold 5, window 3.
`default_nettype none

module windowed_source_rate_alarm #(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  wsra_req_if.sink                          req,
  wsra_rsp_if.source                        rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wsra_pkg::PADDR_W-1:0] paddr,
  input  wire logic [wsra_pkg::PDATA_W-1:0] pwdata,
  output logic      [wsra_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import wsra_pkg::*;

  logic [THR_W-1:0]     alarm_threshold;
  logic [WIN_W-1:0]     window_seconds;
  logic                 busy;
  logic                 go;
  logic                 pend;
  logic [CNT_W-1:0]     pend_count;
  logic                 accept;
  logic                 out_free;
  logic [LOG_DEPTH-1:0] hit_now;
  logic [LOG_DEPTH-1:0] hits;
  logic [LOG_DEPTH-1:0] cell_hit;
  entry_t               chain [LOG_DEPTH+1];
  tally_res_t           tres;
  reg_idx_t             reg_sel;
  logic [CNT_W-1:0]     fire_count;

  assign accept   = req.valid && req.ready;
  assign req.ready = !busy;
  assign out_free = !rsp.valid || rsp.ready;
  assign pready   = 1'b1;
  assign reg_sel  = reg_idx_t'(paddr[2]);
  assign fire_count = CNT_W'(alarm_threshold) + CNT_W'(1);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_threshold <= THR_W'(5);
      window_seconds  <= WIN_W'(3);
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_THRESHOLD: alarm_threshold <= pwdata[THR_W-1:0];
        REG_WINDOW:    window_seconds  <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: prdata = PDATA_W'(alarm_threshold);
      REG_WINDOW:    prdata = PDATA_W'(window_seconds);
      default:       prdata = '0;
    endcase
  end

  // new attempt enters cell 0, the oldest drops off the far end
  assign chain[0].valid  = 1'b1;
  assign chain[0].src    = req.src_addr;
  assign chain[0].tstamp = req.now_seconds;

  for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
    wsra_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (accept),
      .entry_in (chain[i]),
      .key_src  (req.src_addr),
      .key_time (req.now_seconds),
      .window   (window_seconds),
      .entry    (chain[i+1]),
      .hit      (cell_hit[i])
    );
  end

  // the new attempt always counts; the last cell is about to be overwritten
  always_comb begin
    hit_now[0] = 1'b1;
    for (int i = 1; i < LOG_DEPTH; i++) begin
      hit_now[i] = cell_hit[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) hits <= hit_now;
  end

  wsra_tally #(.DEPTH(LOG_DEPTH)) u_tally (
    .clk   (clk),
    .rst   (rst),
    .start (go),
    .hits  (hits),
    .res   (tres)
  );

  function automatic logic [MCOUNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    return (c > CNT_W'(127)) ? MCOUNT_W'(127) : c[MCOUNT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      go        <= 1'b0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      go <= accept;
      if (accept) busy <= 1'b1;
      if (tres.done) begin
        if (out_free) begin
          rsp.valid <= 1'b1;
          busy      <= 1'b0;
        end else begin
          pend <= 1'b1;
        end
      end else if (pend && out_free) begin
        rsp.valid <= 1'b1;
        pend      <= 1'b0;
        busy      <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tres.done) pend_count <= tres.count;
    if (tres.done && out_free) begin
      rsp.alert       <= (tres.count == fire_count);
      rsp.match_count <= sat_count(tres.count);
    end else if (pend && out_free) begin
      rsp.alert       <= (pend_count == fire_count);
      rsp.match_count <= sat_count(pend_count);
    end
  end

  // a new count never lands on a verdict still waiting to be sent
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(tres.done && pend))
    else $error("tally result arrived while a verdict was pending");

  // a verdict is produced only for an attempt in flight
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    tres.done |-> busy)
    else $error("tally finished with no attempt in flight");

  // an accepted attempt starts the tally on the next cycle
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (go && busy))
    else $error("accepted attempt did not start the tally");

  // a pending verdict keeps the block from taking a new attempt
  a_pend_blocks: assert property (@(posedge clk) disable iff (rst)
    pend |-> !req.ready)
    else $error("attempt accepted while a verdict was pending");

endmodule

`default_nettype wire

FILE: tb/windowed_source_rate_alarm_tb.sv
// windowed_source_rate_alarm_tb: self-checking bench for the windowed source rate alarm
// drives attempts over wsra_req_if, checks verdicts on wsra_rsp_if against an in-bench
// log predictor, programs registers over apb; depends on wsra_pkg, wsra_if and the dut
`timescale 1ns / 1ps

module windowed_source_rate_alarm_tb;
  import wsra_pkg::*;

  localparam int unsigned LOG_DEPTH     = 64;
  localparam int unsigned WP_W          = $clog2(LOG_DEPTH);
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          DRAIN_LIMIT   = 5000;
  localparam int          PRINT_CAP     = 40;

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [TIME_W-1:0] stamp;
  } attempt_t;

  typedef struct packed {
    logic                alert;
    logic [MCOUNT_W-1:0] match_count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  wsra_req_if req_ch ();
  wsra_rsp_if rsp_ch ();

  windowed_source_rate_alarm #(
    .LOG_DEPTH(LOG_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // predictor state: ring log of attempts plus register copies
  logic [ADDR_W-1:0] log_src   [LOG_DEPTH];
  logic [TIME_W-1:0] log_stamp [LOG_DEPTH];
  logic              log_used  [LOG_DEPTH];
  logic [WP_W-1:0]   write_pos;
  logic [THR_W-1:0]  thr_cfg;
  logic [WIN_W-1:0]  win_cfg;

  attempt_t pending_attempts[$];
  verdict_t expected_verdicts[$];
  verdict_t want;

  bit in_flight;
  bit steady;
  bit hold_armed;
  int hold_left;
  int cycle_count;
  int errors;
  int attempts_sent;
  int alerts_seen;
  int settings_used;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch @%0d: %s", cycle_count, what);
  endtask

  function automatic verdict_t score_attempt(input logic [ADDR_W-1:0] src,
                                             input logic [TIME_W-1:0] now_s);
    verdict_t v;
    int hits;
    logic [TIME_W-1:0] age;
    log_src[write_pos]   = src;
    log_stamp[write_pos] = now_s;
    log_used[write_pos]  = 1'b1;
    write_pos = (write_pos == WP_W'(LOG_DEPTH - 1)) ? '0 : write_pos + WP_W'(1);
    hits = 0;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      if (log_used[i] && log_src[i] == src) begin
        // unsigned age, so a stamp from the future wraps huge and drops out
        age = now_s - log_stamp[i];
        if (age <= TIME_W'(win_cfg)) hits++;
      end
    end
    v.alert = (hits == int'(thr_cfg) + 1);
    v.match_count = (hits > 127) ? MCOUNT_W'(127) : MCOUNT_W'(hits);
    return v;
  endfunction

  // sample side: register writes, accepted attempts, verdict checks
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_THRESHOLD: thr_cfg = pwdata[THR_W-1:0];
          REG_WINDOW:    win_cfg = pwdata[WIN_W-1:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_verdicts = {expected_verdicts,
                             score_attempt(req_ch.src_addr, req_ch.now_seconds)};
        void'(pending_attempts.pop_front());
        in_flight = 1'b0;
        attempts_sent++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (rsp_ch.alert === 1'b1) alerts_seen++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict beat with no attempt outstanding");
        end else begin
          want = expected_verdicts.pop_front();
          if (rsp_ch.alert !== want.alert)
            report_mismatch($sformatf("alert got %b want %b", rsp_ch.alert, want.alert));
          if (rsp_ch.match_count !== want.match_count)
            report_mismatch($sformatf("match_count got %0d want %0d",
                                      rsp_ch.match_count, want.match_count));
        end
      end
    end
  end

  // attempt driver, fed from pending_attempts
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!in_flight) begin
      if (pending_attempts.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
        req_ch.valid       <= 1'b1;
        req_ch.src_addr    <= pending_attempts[0].src;
        req_ch.now_seconds <= pending_attempts[0].stamp;
        in_flight = 1'b1;
      end else begin
        req_ch.valid       <= 1'b0;
        req_ch.src_addr    <= $urandom;
        req_ch.now_seconds <= $urandom;
      end
    end
  end

  // verdict receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL windowed_source_rate_alarm");
    $finish;
  end

  task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input reg_idx_t idx, input logic [PDATA_W-1:0] wanted);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== wanted)
      report_mismatch($sformatf("reg %s read %h want %h", idx.name(), prdata, wanted));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_attempt(input logic [ADDR_W-1:0] src, input logic [TIME_W-1:0] t);
    attempt_t a;
    a.src = src;
    a.stamp = t;
    pending_attempts = {pending_attempts, a};
  endtask

  task automatic wait_idle();
    while (pending_attempts.size() != 0 || in_flight || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register setting and a burst of attempts drawn from a small source pool
  task automatic run_phase(input logic [PDATA_W-1:0] thr_word,
                           input logic [PDATA_W-1:0] win_word,
                           input int n_items, input int pool_n,
                           input int noise_pct, input int back_pct,
                           input logic [TIME_W-1:0] t_start,
                           input bit calm, input bit squeeze);
    logic [ADDR_W-1:0] pool [8];
    logic [TIME_W-1:0] t;
    logic [ADDR_W-1:0] s;
    int r;
    apb_write(REG_THRESHOLD, thr_word);
    apb_write(REG_WINDOW, win_word);
    apb_read(REG_THRESHOLD, PDATA_W'(thr_word[THR_W-1:0]));
    apb_read(REG_WINDOW, PDATA_W'(win_word[WIN_W-1:0]));
    settings_used++;
    foreach (pool[k]) pool[k] = $urandom;
    t = t_start;
    steady = calm;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < back_pct) t = t - $urandom_range(1, 12);
      else if (r < 40) t = t;
      else if (r < 70) t = t + 1;
      else if (r < 97) t = t + $urandom_range(2, 8);
      else t = t + $urandom;
      if ($urandom_range(0, 99) < noise_pct) s = $urandom;
      else s = pool[3'($urandom_range(0, pool_n - 1))];
      queue_attempt(s, t);
    end
    if (squeeze) begin
      @(posedge clk);
      hold_armed = 1'b1;
    end
    wait_idle();
    steady = 1'b0;
  endtask

  initial begin
    int spin;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.src_addr = '0;
    req_ch.now_seconds = '0;
    rsp_ch.ready = 1'b0;
    in_flight = 1'b0;
    steady = 1'b0;
    hold_armed = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    errors = 0;
    attempts_sent = 0;
    alerts_seen = 0;
    settings_used = 1;
    foreach (log_used[k]) log_used[k] = 1'b0;
    write_pos = '0;
    thr_cfg = THR_W'(5);
    win_cfg = WIN_W'(3);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    apb_read(REG_THRESHOLD, PDATA_W'(5));
    apb_read(REG_WINDOW, PDATA_W'(3));

    // directed: field extremes, ramp to the alert, window edge, time going backwards, wrap
    queue_attempt(32'h0000_0000, 32'd0);
    queue_attempt(32'hFFFF_FFFF, 32'd0);
    queue_attempt(32'h0000_0000, 32'd1);
    queue_attempt(32'h0000_0000, 32'd2);
    queue_attempt(32'h0000_0000, 32'd3);
    queue_attempt(32'h0000_0000, 32'd4);
    repeat (7) queue_attempt(32'h0A00_0001, 32'd10);
    queue_attempt(32'h0A00_0001, 32'd13);
    queue_attempt(32'h0A00_0001, 32'd14);
    queue_attempt(32'h0A00_0001, 32'd12);
    queue_attempt(32'h5555_5555, 32'h5555_5555);
    queue_attempt(32'hAAAA_AAAA, 32'hAAAA_AAAA);
    queue_attempt(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_attempt(32'hFFFF_FFFF, 32'd0);
    queue_attempt(32'hFFFF_FFFF, 32'd2);
    queue_attempt(32'h0000_0000, 32'd0);
    wait_idle();

    run_phase(32'd0, 32'd0, 200, 4, 10, 3, $urandom, 1'b0, 1'b0);
    // one source, widest window: count climbs to the full log depth
    run_phase(32'd63, 32'd65535, 150, 1, 0, 0, $urandom, 1'b0, 1'b0);
    run_phase(32'd2, 32'd5, 250, 6, 10, 3, $urandom, 1'b0, 1'b1);
    run_phase(32'd7, 32'd20, 300, 3, 10, 3, $urandom, 1'b1, 1'b0);
    run_phase($urandom, $urandom, 300, 8, 10, 3, $urandom, 1'b0, 1'b0);
    // junk above the register widths, clock rolling over 2^32
    run_phase(32'hFFFF_FFC1, 32'hFFFF_0001, 200, 2, 10, 3, 32'hFFFF_FF00, 1'b0, 1'b0);
    run_phase(32'd5, 32'd3, 200, 5, 10, 3, $urandom, 1'b0, 1'b0);

    spin = 0;
    while ((pending_attempts.size() != 0 || in_flight || expected_verdicts.size() != 0)
           && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_attempts.size() != 0 || expected_verdicts.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived, %0d attempts never taken",
                                expected_verdicts.size(), pending_attempts.size()));

    $display("covered %0d attempts under %0d register settings, %0d alerts raised",
             attempts_sent, settings_used, alerts_seen);
    $display("with a %0d-cycle verdict hold-off, a no-idle stretch and %0d mismatches",
             HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("PASS windowed_source_rate_alarm");
    end else begin
      $display("FAIL windowed_source_rate_alarm");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/wsra_pkg.sv
sv/wsra_if.sv
sv/wsra_cell.sv
sv/wsra_tally.sv
sv/windowed_source_rate_alarm.sv
tb/windowed_source_rate_alarm_tb.sv
